>>> hdl/rfu_pkg.sv
// shared types, constants and decode functions for the rtc fields to unix seconds unit
`default_nettype none
package rfu_pkg;

  localparam logic [14:0] YEAR_EPOCH         = 15'd1970;
  localparam logic [12:0] LEAPS_BEFORE_EPOCH = 13'd477;
  localparam logic [31:0] SECONDS_PER_DAY    = 32'd86400;
  localparam logic [19:0] SECONDS_PER_HOUR   = 20'd3600;
  localparam logic [19:0] SECONDS_PER_MINUTE = 20'd60;
  localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
  localparam logic [7:0]  CENTURY_ABSENT_LO  = 8'h00;
  localparam logic [7:0]  CENTURY_ABSENT_HI  = 8'hFF;
  localparam logic [7:0]  PIVOT_YEAR         = 8'd80;
  localparam logic [7:0]  CENTURY_20XX       = 8'd20;
  localparam logic [7:0]  CENTURY_19XX       = 8'd19;
  localparam logic [3:0]  LAST_MONTH         = 4'd12;

  typedef struct packed {
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] century;
  } raw_t;

  typedef struct packed {
    logic [14:0] year;
    logic [7:0]  cent_prev;
    logic [6:0]  rem_prev;
    logic        after_epoch;
    logic        leap_day;
    logic [8:0]  month_days;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } fields_t;

  typedef struct packed {
    logic [31:0] days;
    logic [19:0] tod;
    logic [14:0] year;
  } days_t;

  // high nibble times ten plus low nibble, no digit rejected
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

>>> hdl/rtc_fields_to_unix_seconds_unit.sv
// an accepted item passes the input, field, day and result stages in order before out_valid
// throughput: one item per cycle; a stalled output holds the pipe back stage by stage
// the day-to-seconds multiply by 86400 and the time-of-day add occupy the last stage
// reset: synchronous, clears all stage valid flags and returns binary_mode to bcd
// top level of the rtc fields to unix seconds converter
`default_nettype none
module rtc_fields_to_unix_seconds_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  second_raw,
  input  wire logic [7:0]  minute_raw,
  input  wire logic [7:0]  hour_raw,
  input  wire logic [7:0]  day_raw,
  input  wire logic [7:0]  month_raw,
  input  wire logic [7:0]  year_raw,
  input  wire logic [7:0]  century_raw,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      unix_seconds,
  output logic [14:0]      full_year
);
  import rfu_pkg::*;

  logic    binary_mode;
  logic    s1_valid, s2_valid, s3_valid;
  raw_t    s1_raw;
  fields_t s1_fields, s2_fields;
  days_t   s2_days, s3_days;
  logic [31:0] s3_secs;
  logic    adv1, adv2, adv3, adv4;

  assign adv4     = !out_valid || out_ready;
  assign adv3     = !s3_valid || adv4;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      binary_mode <= 1'b0;
    end else if (cfg_write) begin
      binary_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid  <= in_valid;
      if (adv2) s2_valid  <= s1_valid;
      if (adv3) s3_valid  <= s2_valid;
      if (adv4) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_raw <= '{second: second_raw, minute: minute_raw, hour: hour_raw, day: day_raw,
                  month: month_raw, year: year_raw, century: century_raw};
    end
    if (adv2) s2_fields <= s1_fields;
    if (adv3) s3_days   <= s2_days;
    if (adv4) begin
      unix_seconds <= s3_secs;
      full_year    <= s3_days.year;
    end
  end

  rfu_decode u_decode (
    .binary_mode (binary_mode),
    .raw         (s1_raw),
    .fields      (s1_fields)
  );

  rfu_day_count u_day_count (
    .fields (s2_fields),
    .days   (s2_days)
  );

  rfu_seconds u_seconds (
    .days (s3_days),
    .secs (s3_secs)
  );

`ifndef SYNTH
  // a full pipe behind a stalled output must refuse new items
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && s3_valid && s2_valid && s1_valid) |-> !in_ready)
    else $error("input accepted while pipe is full and stalled");

  // an accepted item lands in the input stage
  a_capture: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted item lost at input stage");

  // the last stage hands its item to the output when the output can move
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && adv4) |=> out_valid)
    else $error("item lost between day stage and output");

  // largest reachable year is 254 centuries plus 99
  a_year_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (full_year <= 15'd25499))
    else $error("full_year out of range");
`endif

endmodule
`default_nettype wire

>>> hdl/rfu_decode.sv
// byte decode, year assembly, leap test and month table lookup
`default_nettype none
module rfu_decode (
  input  wire logic           binary_mode,
  input  wire rfu_pkg::raw_t  raw,
  output rfu_pkg::fields_t    fields
);
  import rfu_pkg::*;

  logic [7:0] sec, min, hr, dy, mon, yr, cen_val;
  logic       cen_present;
  logic [7:0] yr_rem;
  logic [7:0] hund;
  logic [7:0] cent;
  logic [6:0] rem;
  logic [3:0] mon_idx;
  logic       leap;

  always_comb begin
    sec     = binary_mode ? raw.second  : bcd_to_bin(raw.second);
    min     = binary_mode ? raw.minute  : bcd_to_bin(raw.minute);
    hr      = binary_mode ? raw.hour    : bcd_to_bin(raw.hour);
    dy      = binary_mode ? raw.day     : bcd_to_bin(raw.day);
    mon     = binary_mode ? raw.month   : bcd_to_bin(raw.month);
    yr      = binary_mode ? raw.year    : bcd_to_bin(raw.year);
    cen_val = binary_mode ? raw.century : bcd_to_bin(raw.century);
    // presence is judged on the raw byte
    cen_present = (raw.century != CENTURY_ABSENT_LO) && (raw.century != CENTURY_ABSENT_HI);

    // decoded year can reach 165 or 255, split into hundreds and remainder
    if (yr >= 8'd200) begin
      yr_rem = yr - 8'd200;
      hund   = 8'd2;
    end else if (yr >= 8'd100) begin
      yr_rem = yr - 8'd100;
      hund   = 8'd1;
    end else begin
      yr_rem = yr;
      hund   = 8'd0;
    end
    rem = yr_rem[6:0];

    if (cen_present) begin
      cent = cen_val;
    end else begin
      cent = ((yr < PIVOT_YEAR) ? CENTURY_20XX : CENTURY_19XX) + hund;
    end

    fields.year = 15'(cent) * 15'd100 + 15'(rem);

    // year - 1 split the same way for the leap count
    if (rem == 7'd0) begin
      fields.cent_prev = cent - 8'd1;
      fields.rem_prev  = 7'd99;
    end else begin
      fields.cent_prev = cent;
      fields.rem_prev  = rem - 7'd1;
    end

    fields.after_epoch = fields.year > YEAR_EPOCH;

    leap = (rem != 7'd0) ? (rem[1:0] == 2'b00) : (cent[1:0] == 2'b00);
    fields.leap_day = leap && (mon > 8'd2);

    mon_idx = (mon > 8'(LAST_MONTH)) ? LAST_MONTH : mon[3:0];
    fields.month_days = days_before_month(mon_idx);

    fields.day    = dy;
    fields.hour   = hr;
    fields.minute = min;
    fields.second = sec;
  end

endmodule
`default_nettype wire

>>> hdl/rfu_day_count.sv
// day count since the epoch and time of day in seconds
`default_nettype none
module rfu_day_count (
  input  wire rfu_pkg::fields_t fields,
  output rfu_pkg::days_t        days
);
  import rfu_pkg::*;

  logic [14:0] year_span;
  logic [23:0] whole_years;
  logic [12:0] leaps;
  logic [23:0] span_days;
  logic [31:0] base_days;

  always_comb begin
    year_span   = fields.year - YEAR_EPOCH;
    whole_years = 24'(year_span) * 24'(DAYS_PER_YEAR);
    // leaps in 1..n with n = 100*c + r is 24*c + r/4 + c/4
    leaps = 13'(fields.cent_prev) * 13'd24 + 13'(fields.rem_prev[6:2])
          + 13'(fields.cent_prev[7:2]);
    span_days = whole_years + 24'(leaps) - 24'(LEAPS_BEFORE_EPOCH);
    base_days = fields.after_epoch ? 32'(span_days) : 32'd0;

    // day zero wraps the count
    days.days = base_days + 32'(fields.leap_day) + 32'(fields.month_days)
              + 32'(fields.day) - 32'd1;
    days.tod  = 20'(fields.hour) * SECONDS_PER_HOUR
              + 20'(fields.minute) * SECONDS_PER_MINUTE + 20'(fields.second);
    days.year = fields.year;
  end

endmodule
`default_nettype wire

>>> hdl/rfu_seconds.sv
// final scaling of the day count to seconds, modulo 2^32
`default_nettype none
module rfu_seconds (
  input  wire rfu_pkg::days_t days,
  output logic [31:0]         secs
);
  import rfu_pkg::*;

  assign secs = days.days * SECONDS_PER_DAY + 32'(days.tod);

endmodule
`default_nettype wire
